>>> rtl/wrmc_pkg.sv
package wrmc_pkg;

  // Field and register widths
  localparam int unsigned DATA_W    = 48;
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned BYTE_W    = 8;

  // Default bucket count
  localparam int unsigned BUCKETS_DEF = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN_TICKS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UP_TO_HYBRID   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UP_TO_MULTI    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DOWN_TO_HYBRID = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DOWN_TO_SINGLE = 3'd5;

  // Register reset values
  localparam logic [DATA_W-1:0] WINDOW_LEN_RST     = 48'd1024;
  localparam logic [DATA_W-1:0] COOLDOWN_TICKS_RST = 48'd0;
  localparam logic [CNT_W-1:0]  UP_TO_HYBRID_RST   = 32'd100;
  localparam logic [CNT_W-1:0]  UP_TO_MULTI_RST    = 32'd1000;
  localparam logic [CNT_W-1:0]  DOWN_TO_HYBRID_RST = 32'd500;
  localparam logic [CNT_W-1:0]  DOWN_TO_SINGLE_RST = 32'd50;

  // Request kinds
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_EVAL  = 1'b1;

  // Operating modes
  typedef enum logic [MODE_W-1:0] {
    MODE_SINGLE = 2'd0,
    MODE_HYBRID = 2'd1,
    MODE_MULTI  = 2'd2
  } mode_e;

  // Controller to datapath commands
  typedef struct packed {
    logic latch_in;    // capture the accepted item
    logic div_start;   // start the shared divider
    logic div_span;    // divider operands: max(window, buckets) / buckets
    logic span_load;   // capture bucket span
    logic epoch_load;  // capture epoch, slot, window floor, cooldown check
    logic rd;          // bucket memory read
    logic rd_scan;     // read address from scan counter (else slot)
    logic bucket_wr;   // write back the updated bucket
    logic mode_upd;    // apply the mode decision
    logic out_load;    // load result register
  } wrmc_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic div_done;
    logic span_ok;
    logic req_eval;
    logic scan_last;
    logic out_free;
  } wrmc_sts_t;

endpackage

>>> rtl/wrmc_divider.sv
// Restoring divider, one quotient bit per cycle, MSB first. Also keeps the
// quotient modulo BUCKETS as the bits come out.
module wrmc_divider #(
  parameter int unsigned BUCKETS = wrmc_pkg::BUCKETS_DEF,
  localparam int unsigned IDX_W  = $clog2(BUCKETS)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [wrmc_pkg::DATA_W-1:0] dividend_i,
  input  logic [wrmc_pkg::DATA_W-1:0] divisor_i,
  output logic                        done_o,
  output logic [wrmc_pkg::DATA_W-1:0] quot_o,
  output logic [IDX_W-1:0]            qmod_o
);

  localparam int unsigned DW    = wrmc_pkg::DATA_W;
  localparam int unsigned CNT_W = $clog2(DW + 1);
  localparam logic [IDX_W:0] B_EXT = (IDX_W + 1)'(BUCKETS);

  logic [DW:0]       rem_q, rem_d;
  logic [DW-1:0]     quot_q, quot_d;
  logic [DW-1:0]     dvs_q;
  logic [IDX_W-1:0]  mod_q, mod_d;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q, done_q;

  logic [DW:0]       rem_sh;
  logic              qbit;
  logic [IDX_W:0]    mod_sh;

  // One restoring step
  always_comb begin
    rem_sh = {rem_q[DW-1:0], quot_q[DW-1]};
    qbit   = (rem_sh >= {1'b0, dvs_q});
    rem_d  = qbit ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
    quot_d = {quot_q[DW-2:0], qbit};
    mod_sh = {mod_q, qbit};
    mod_d  = (mod_sh >= B_EXT) ? IDX_W'(mod_sh - B_EXT) : IDX_W'(mod_sh);
  end

  // Control: busy flag, step counter, done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CNT_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Operand and partial result registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      quot_q <= dividend_i;
      dvs_q  <= divisor_i;
      mod_q  <= '0;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      quot_q <= quot_d;
      mod_q  <= mod_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign qmod_o = mod_q;

endmodule

>>> rtl/wrmc_datapath.sv
// Configuration registers, bucket store, window sum and mode register.
module wrmc_datapath #(
  parameter int unsigned BUCKETS = wrmc_pkg::BUCKETS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  wrmc_pkg::wrmc_cmd_t            cmd_i,
  output wrmc_pkg::wrmc_sts_t            sts_o,
  input  logic                           cfg_we_i,
  input  logic [wrmc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [wrmc_pkg::DATA_W-1:0]    cfg_data_i,
  input  logic                           req_type_i,
  input  logic [wrmc_pkg::DATA_W-1:0]    event_time_i,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic [wrmc_pkg::MODE_W-1:0]    mode_o
);

  localparam int unsigned DW    = wrmc_pkg::DATA_W;
  localparam int unsigned CW    = wrmc_pkg::CNT_W;
  localparam int unsigned IDX_W = $clog2(BUCKETS);
  localparam int unsigned ACC_W = CW + IDX_W;
  localparam logic [DW-1:0] B_DW   = DW'(BUCKETS);
  localparam logic [DW:0]   B_DW1  = (DW + 1)'(BUCKETS);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(BUCKETS - 1);

  // Configuration registers
  logic [DW-1:0] window_q, cool_q;
  logic [CW-1:0] th_uh_q, th_um_q, th_dh_q, th_ds_q;
  logic          span_ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q  <= wrmc_pkg::WINDOW_LEN_RST;
      cool_q    <= wrmc_pkg::COOLDOWN_TICKS_RST;
      th_uh_q   <= wrmc_pkg::UP_TO_HYBRID_RST;
      th_um_q   <= wrmc_pkg::UP_TO_MULTI_RST;
      th_dh_q   <= wrmc_pkg::DOWN_TO_HYBRID_RST;
      th_ds_q   <= wrmc_pkg::DOWN_TO_SINGLE_RST;
      span_ok_q <= 1'b0;
    end else begin
      if (cmd_i.span_load) begin
        span_ok_q <= 1'b1;
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          wrmc_pkg::CFG_WINDOW_LEN: begin
            window_q  <= cfg_data_i;
            span_ok_q <= 1'b0;
          end
          wrmc_pkg::CFG_COOLDOWN_TICKS: cool_q  <= cfg_data_i;
          wrmc_pkg::CFG_UP_TO_HYBRID:   th_uh_q <= cfg_data_i[CW-1:0];
          wrmc_pkg::CFG_UP_TO_MULTI:    th_um_q <= cfg_data_i[CW-1:0];
          wrmc_pkg::CFG_DOWN_TO_HYBRID: th_dh_q <= cfg_data_i[CW-1:0];
          wrmc_pkg::CFG_DOWN_TO_SINGLE: th_ds_q <= cfg_data_i[CW-1:0];
          default: ;
        endcase
      end
    end
  end

  // Accepted item
  logic          req_q;
  logic [DW-1:0] time_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      req_q  <= req_type_i;
      time_q <= event_time_i;
    end
  end

  // Shared divider: span = max(window, B) / B, then epoch = time / span
  logic [DW-1:0]    span_q;
  logic [DW-1:0]    div_a, div_b;
  logic             div_done;
  logic [DW-1:0]    div_quot;
  logic [IDX_W-1:0] div_qmod;

  assign div_a = cmd_i.div_span ? ((window_q < B_DW) ? B_DW : window_q) : time_q;
  assign div_b = cmd_i.div_span ? B_DW : span_q;

  wrmc_divider #(
    .BUCKETS (BUCKETS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .qmod_o     (div_qmod)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.span_load) begin
      span_q <= div_quot;
    end
  end

  // Epoch, slot, oldest epoch in window, cooldown check
  logic [DW-1:0]    epoch_q, oldest_q;
  logic [IDX_W-1:0] slot_q;
  logic             may_q;
  logic [DW:0]      epoch_p1;
  logic [DW-1:0]    since_last;
  logic [DW-1:0]    last_q;

  assign epoch_p1   = {1'b0, div_quot} + (DW + 1)'(1);
  assign since_last = time_q - last_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.epoch_load) begin
      epoch_q  <= div_quot;
      slot_q   <= div_qmod;
      oldest_q <= (epoch_p1 >= B_DW1) ? DW'(epoch_p1 - B_DW1) : '0;
      may_q    <= (last_q == '0) || ((time_q >= last_q) && (since_last >= cool_q));
    end
  end

  // Bucket store: epoch and count per slot, valid bits read as empty
  logic [DW-1:0]    mem_epoch_q [BUCKETS];
  logic [CW-1:0]    mem_cnt_q   [BUCKETS];
  logic [BUCKETS-1:0] vld_q;
  logic [IDX_W-1:0] scan_idx_q;
  logic [IDX_W-1:0] rd_addr;
  logic [DW-1:0]    rd_epoch_q;
  logic [CW-1:0]    rd_cnt_q;
  logic             rd_vld_q;
  logic             add_pend_q;
  logic             hit;
  logic [CW-1:0]    new_cnt;

  assign rd_addr = cmd_i.rd_scan ? scan_idx_q : slot_q;
  assign hit     = rd_vld_q && (rd_epoch_q == epoch_q);
  assign new_cnt = !hit ? CW'(1) : ((&rd_cnt_q) ? rd_cnt_q : rd_cnt_q + CW'(1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      rd_epoch_q <= mem_epoch_q[rd_addr];
      rd_cnt_q   <= mem_cnt_q[rd_addr];
    end
    if (cmd_i.bucket_wr) begin
      mem_epoch_q[slot_q] <= epoch_q;
      mem_cnt_q[slot_q]   <= new_cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= '0;
      rd_vld_q   <= 1'b0;
      add_pend_q <= 1'b0;
      scan_idx_q <= '0;
    end else begin
      add_pend_q <= cmd_i.rd && cmd_i.rd_scan;
      if (cmd_i.rd) begin
        rd_vld_q <= vld_q[rd_addr];
      end
      if (cmd_i.bucket_wr) begin
        vld_q[slot_q] <= 1'b1;
      end
      if (cmd_i.epoch_load) begin
        scan_idx_q <= '0;
      end else if (cmd_i.rd && cmd_i.rd_scan) begin
        scan_idx_q <= (scan_idx_q == IDX_LAST) ? '0 : scan_idx_q + IDX_W'(1);
      end
    end
  end

  // Window sum, one bucket per cycle
  logic [ACC_W-1:0] acc_q;
  logic             in_win;

  assign in_win = rd_vld_q && (rd_epoch_q >= oldest_q) && (rd_epoch_q <= epoch_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.epoch_load) begin
      acc_q <= '0;
    end else if (add_pend_q && in_win) begin
      acc_q <= acc_q + ACC_W'(rd_cnt_q);
    end
  end

  // Mode decision with hysteresis
  wrmc_pkg::mode_e  mode_q, mode_nx;
  logic             sw;

  always_comb begin
    mode_nx = mode_q;
    case (mode_q)
      wrmc_pkg::MODE_SINGLE: begin
        if (acc_q >= ACC_W'(th_uh_q)) mode_nx = wrmc_pkg::MODE_HYBRID;
      end
      wrmc_pkg::MODE_HYBRID: begin
        if (acc_q >= ACC_W'(th_um_q)) begin
          mode_nx = wrmc_pkg::MODE_MULTI;
        end else if (acc_q <= ACC_W'(th_ds_q)) begin
          mode_nx = wrmc_pkg::MODE_SINGLE;
        end
      end
      wrmc_pkg::MODE_MULTI: begin
        if (acc_q <= ACC_W'(th_dh_q)) mode_nx = wrmc_pkg::MODE_HYBRID;
      end
      default: mode_nx = mode_q;
    endcase
  end

  assign sw = may_q && (mode_nx != mode_q);

  // Mode state and result register
  logic                          out_valid_q;
  logic [wrmc_pkg::MODE_W-1:0]   out_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= wrmc_pkg::MODE_SINGLE;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.mode_upd && sw) begin
        mode_q <= mode_nx;
        last_q <= time_q;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_mode_q <= sw ? mode_nx : mode_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign mode_o      = out_mode_q;

  assign sts_o.div_done  = div_done;
  assign sts_o.span_ok   = span_ok_q;
  assign sts_o.req_eval  = (req_q == wrmc_pkg::REQ_EVAL);
  assign sts_o.scan_last = (scan_idx_q == IDX_LAST);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

endmodule

>>> rtl/wrmc_ctrl.sv
// Sequencer: span and epoch divisions, bucket update or window scan, decision.
module wrmc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  wrmc_pkg::wrmc_sts_t sts_i,
  output wrmc_pkg::wrmc_cmd_t cmd_o
);

  typedef enum logic [9:0] {
    S_IDLE      = 10'b0000000001,
    S_SPAN_GO   = 10'b0000000010,
    S_SPAN      = 10'b0000000100,
    S_EPOCH_GO  = 10'b0000001000,
    S_EPOCH     = 10'b0000010000,
    S_RD        = 10'b0000100000,
    S_WR        = 10'b0001000000,
    S_SCAN      = 10'b0010000000,
    S_SCAN_TAIL = 10'b0100000000,
    S_DECIDE    = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = sts_i.span_ok ? S_EPOCH_GO : S_SPAN_GO;
        end
      end
      S_SPAN_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_span  = 1'b1;
        state_d         = S_SPAN;
      end
      S_SPAN: begin
        if (sts_i.div_done) begin
          cmd_o.span_load = 1'b1;
          state_d         = S_EPOCH_GO;
        end
      end
      S_EPOCH_GO: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_EPOCH;
      end
      S_EPOCH: begin
        if (sts_i.div_done) begin
          cmd_o.epoch_load = 1'b1;
          state_d          = sts_i.req_eval ? S_SCAN : S_RD;
        end
      end
      S_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_WR;
      end
      S_WR: begin
        cmd_o.bucket_wr = 1'b1;
        state_d         = S_IDLE;
      end
      S_SCAN: begin
        cmd_o.rd      = 1'b1;
        cmd_o.rd_scan = 1'b1;
        if (sts_i.scan_last) begin
          state_d = S_SCAN_TAIL;
        end
      end
      S_SCAN_TAIL: begin
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        if (sts_i.out_free) begin
          cmd_o.mode_upd = 1'b1;
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

>>> rtl/windowed_rate_mode_controller_unit.sv
// Windowed write-rate mode controller. Write events (tuser 0) count into one
// of BUCKETS time buckets; evaluate requests (tuser 1) sum the buckets of the
// last BUCKETS epochs and step the mode (single, hybrid, multilevel) with
// hysteresis and a cooldown, returning one result carrying the mode. Items
// are handled one at a time; a shared 48-bit divider producing one quotient
// bit per cycle sets the pace. A write event divides its time by the span,
// then reads and writes back its bucket; an evaluate request divides too,
// then reads every bucket, one bucket read per cycle, and may wait for the
// result register to drain. The first item after reset or after a
// window_len write first derives the bucket span with the same divider.
// Configuration writes are always ready and take effect in the next cycle.
module windowed_rate_mode_controller_unit #(
  parameter int unsigned BUCKETS = wrmc_pkg::BUCKETS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Input stream
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [wrmc_pkg::DATA_W-1:0]    s_axis_tdata_i,  // [47:0] event_time
  input  logic                           s_axis_tuser_i,  // [0] req_type
  // Result stream
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [wrmc_pkg::BYTE_W-1:0]    m_axis_tdata_o,  // [1:0] mode, [7:2] zero
  // Configuration write
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [wrmc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [wrmc_pkg::DATA_W-1:0]    cfg_data_i
);

  wrmc_pkg::wrmc_cmd_t         cmd;
  wrmc_pkg::wrmc_sts_t         sts;
  logic [wrmc_pkg::MODE_W-1:0] mode;

  assign cfg_ready_o = 1'b1;

  wrmc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  wrmc_datapath #(
    .BUCKETS (BUCKETS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .req_type_i   (s_axis_tuser_i),
    .event_time_i (s_axis_tdata_i),
    .out_ready_i  (m_axis_tready_i),
    .out_valid_o  (m_axis_tvalid_o),
    .mode_o       (mode)
  );

  assign m_axis_tdata_o = {{(wrmc_pkg::BYTE_W - wrmc_pkg::MODE_W){1'b0}}, mode};

  // Reported mode is never the unused code
  a_mode_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[1:0] != 2'b11))
    else $error("reported mode code out of range");

  // A new result only appears after an item was being worked on
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(!s_axis_tready_o))
    else $error("result raised while controller was idle");

  // Bucket write-back only for write events
  a_write_only_events: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.bucket_wr |-> !sts.req_eval)
    else $error("bucket written during an evaluate request");

  // Divider never finishes in the cycle after it starts
  a_div_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |=> !sts.div_done)
    else $error("divider done too early");

endmodule
